// ----- rtl/tagged_record_deframer_highlight_unit_defines.svh -----
// Assertion macros used by the checker.
`ifndef TAGGED_RECORD_DEFRAMER_HIGHLIGHT_UNIT_DEFINES_SVH
`define TAGGED_RECORD_DEFRAMER_HIGHLIGHT_UNIT_DEFINES_SVH

// Checked outside reset.
`define TRDH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TRDH_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/trdh_pkg.sv -----
`timescale 1ns / 1ps

package trdh_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int FIFO_DEPTH_DEF  = 4;

	localparam logic [7:0] MARKER_RESET = 8'h21;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_BRKT  = 8'h5B;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_M     = 8'h6D;

	typedef enum logic [1:0] {
		CMD_BYTE     = 2'd0,
		CMD_BYTE_OFF = 2'd1,
		CMD_ON       = 2'd2,
		CMD_OFF      = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	typedef logic [2:0] seq_idx_t;

	function automatic logic [7:0] seq_on_byte(seq_idx_t i);
		logic [7:0] b;
		case (i)
			3'd0:    b = CH_ESC;
			3'd1:    b = CH_BRKT;
			3'd2:    b = CH_THREE;
			3'd3:    b = CH_ONE;
			default: b = CH_M;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] seq_off_byte(seq_idx_t i);
		logic [7:0] b;
		case (i)
			3'd0:    b = CH_ESC;
			3'd1:    b = CH_BRKT;
			3'd2:    b = CH_ZERO;
			default: b = CH_M;
		endcase
		return b;
	endfunction

	function automatic seq_idx_t cmd_last_idx(cmd_kind_t k);
		seq_idx_t r;
		unique case (k)
			CMD_BYTE:     r = 3'd0;
			CMD_BYTE_OFF: r = 3'd4;
			CMD_ON:       r = 3'd4;
			CMD_OFF:      r = 3'd3;
			default:      r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] cmd_byte(cmd_t c, seq_idx_t i);
		logic [7:0] b;
		unique case (c.kind)
			CMD_BYTE:     b = c.data;
			CMD_BYTE_OFF: b = (i == 3'd0) ? c.data : seq_off_byte(i - 3'd1);
			CMD_ON:       b = seq_on_byte(i);
			CMD_OFF:      b = seq_off_byte(i);
			default:      b = c.data;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/trdh_front.sv -----
`timescale 1ns / 1ps

module trdh_front #(
	parameter int LENGTH_BITS = trdh_pkg::LENGTH_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           marker_tag_we,
	input  logic [7:0]     marker_tag_wdata,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     in_byte,
	input  logic           q_full,
	output logic           push,
	output trdh_pkg::cmd_t push_cmd
);
	import trdh_pkg::*;

	logic [7:0]             marker_q;
	logic [1:0]             hdr_idx_q;
	logic [7:0]             tag_q;
	logic [7:0]             len_hi_q;
	logic [LENGTH_BITS-1:0] remaining_q;
	logic                   highlight_q;

	logic                   accept;
	logic                   in_payload;
	logic                   tag_match;
	logic [15:0]            len_full;
	logic [LENGTH_BITS-1:0] len_w;

	assign in_stall   = q_full;
	assign accept     = in_valid && !q_full;
	assign in_payload = remaining_q != '0;
	assign tag_match  = tag_q == marker_q;
	assign len_full   = {len_hi_q, in_byte};
	assign len_w      = len_full[LENGTH_BITS-1:0];

	always_comb begin
		push          = 1'b0;
		push_cmd.kind = CMD_BYTE;
		push_cmd.data = in_byte;
		if (in_payload) begin
			push = accept;
			if (remaining_q == LENGTH_BITS'(1) && highlight_q) begin
				push_cmd.kind = CMD_BYTE_OFF;
			end
		end else if (hdr_idx_q == 2'd3 && tag_match) begin
			push          = accept;
			push_cmd.kind = (len_w != '0) ? CMD_ON : CMD_OFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q    <= MARKER_RESET;
			hdr_idx_q   <= 2'd0;
			tag_q       <= 8'd0;
			len_hi_q    <= 8'd0;
			remaining_q <= '0;
			highlight_q <= 1'b0;
		end else begin
			if (marker_tag_we) begin
				marker_q <= marker_tag_wdata;
			end
			if (accept) begin
				if (in_payload) begin
					remaining_q <= remaining_q - LENGTH_BITS'(1);
					if (remaining_q == LENGTH_BITS'(1)) begin
						highlight_q <= 1'b0;
					end
				end else begin
					hdr_idx_q <= hdr_idx_q + 2'd1;
					case (hdr_idx_q)
						2'd0: tag_q <= in_byte;
						2'd2: len_hi_q <= in_byte;
						2'd3: begin
							remaining_q <= len_w;
							highlight_q <= tag_match && (len_w != '0);
						end
						default: ;
					endcase
				end
			end
		end
	end

endmodule

// ----- rtl/trdh_fifo.sv -----
`timescale 1ns / 1ps

module trdh_fifo #(
	parameter int DEPTH = trdh_pkg::FIFO_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  trdh_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output trdh_pkg::cmd_t head,
	output logic           empty
);
	import trdh_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/trdh_back.sv -----
`timescale 1ns / 1ps

module trdh_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  trdh_pkg::cmd_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic           last
);
	import trdh_pkg::*;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	seq_idx_t   idx_q;

	logic advance;
	logic fire;
	logic final_byte;

	assign advance    = !out_valid_q || !out_stall;
	assign fire       = advance && !empty;
	assign final_byte = idx_q == cmd_last_idx(head.kind);
	assign pop        = fire && final_byte;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= cmd_byte(head, idx_q);
			last_q     <= final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= !empty;
			end
			if (fire) begin
				idx_q <= final_byte ? '0 : idx_q + 3'd1;
			end
		end
	end

endmodule

// ----- rtl/tagged_record_deframer_highlight_unit.sv -----
`timescale 1ns / 1ps

// Tag-length-value deframer: takes one stream byte per cycle (4-byte header of tag,
// ignored byte and big-endian length, then payload). Header bytes give no output;
// payload bytes leave one per cycle unless stalled. Records whose tag equals
// marker_tag get ESC[31m ahead of the payload and ESC[0m after it, one output
// byte per cycle unless stalled, so such a record costs 9 extra output bytes
// (an empty one gets only ESC[0m, 4 bytes). A command queue of FIFO_DEPTH entries
// sits between the header parser and the output sequencer; the input stalls only
// while that queue is full. marker_tag is sampled when a header completes and
// should be written while the block is idle.
module tagged_record_deframer_highlight_unit #(
	parameter int LENGTH_BITS = trdh_pkg::LENGTH_BITS_DEF,
	parameter int FIFO_DEPTH  = trdh_pkg::FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       marker_tag_we,
	input  logic [7:0] marker_tag_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last
);
	import trdh_pkg::*;

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	cmd_t push_cmd;
	cmd_t head_cmd;

	trdh_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.marker_tag_we    (marker_tag_we),
		.marker_tag_wdata (marker_tag_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_byte          (in_byte),
		.q_full           (q_full),
		.push             (q_push),
		.push_cmd         (push_cmd)
	);

	trdh_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (head_cmd),
		.empty    (q_empty)
	);

	trdh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (head_cmd),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

// ----- rtl/trdh_checker.sv -----
`timescale 1ns / 1ps

`include "tagged_record_deframer_highlight_unit_defines.svh"

module trdh_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last
);

	// stalled output transaction holds
	`TRDH_ASSERT(a_out_hold, out_valid && out_stall |=> $stable({out_valid, out_byte, last}), "hold")

	// stalled input transaction holds
	`TRDH_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(in_byte), "input hold")

	// bytes of one burst leave back to back
	`TRDH_ASSERT(a_burst_cont, out_valid && !out_stall && !last |=> out_valid, "burst gap")

	`TRDH_ASSERT_ALWAYS(a_rst_out, !arst_n |-> !out_valid, "output valid during reset")

	`TRDH_ASSERT_ALWAYS(a_rst_in, !arst_n |-> !in_stall, "input stalled during reset")

endmodule

bind tagged_record_deframer_highlight_unit trdh_checker u_trdh_checker (.*);
